/* sv/plbi_pkg.sv */
`default_nettype none

package plbi_pkg;

    // Word and field geometry of the three-level bitmap.
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int PRICE_W   = 18;
    localparam int OP_W      = 2;
    localparam int LEAF_AW   = PRICE_W - BIT_W;
    localparam int MID_AW    = LEAF_AW - BIT_W;

    // One memory holds both sides; the side bit is the top address bit.
    localparam int LEAF_MEM_AW    = LEAF_AW + 1;
    localparam int MID_MEM_AW     = MID_AW + 1;
    localparam int LEAF_MEM_DEPTH = 1 << LEAF_MEM_AW;
    localparam int MID_MEM_DEPTH  = 1 << MID_MEM_AW;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [BIT_W-1:0]     bit_idx_t;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Side codes.
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Position of the lowest set bit, found byte first; 0 for a zero word.
    function automatic bit_idx_t low_bit(input word_t w);
        logic [7:0] nz;
        logic [2:0] byte_i;
        logic [7:0] sel;
        logic [2:0] bit_i;
        for (int i = 0; i < 8; i++) begin
            nz[i] = |w[8*i +: 8];
        end
        byte_i = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (nz[i]) begin
                byte_i = 3'(i);
            end
        end
        sel = w[{byte_i, 3'b000} +: 8];
        bit_i = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (sel[i]) begin
                bit_i = 3'(i);
            end
        end
        return {byte_i, bit_i};
    endfunction

    // Position of the highest set bit, found byte first; 0 for a zero word.
    function automatic bit_idx_t high_bit(input word_t w);
        logic [7:0] nz;
        logic [2:0] byte_i;
        logic [7:0] sel;
        logic [2:0] bit_i;
        for (int i = 0; i < 8; i++) begin
            nz[i] = |w[8*i +: 8];
        end
        byte_i = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (nz[i]) begin
                byte_i = 3'(i);
            end
        end
        sel = w[{byte_i, 3'b000} +: 8];
        bit_i = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (sel[i]) begin
                bit_i = 3'(i);
            end
        end
        return {byte_i, bit_i};
    endfunction

endpackage

`default_nettype wire

/* sv/price_level_bitmap_index_top.sv */
// Channel   Direction  Handshake                 Payload
// command   in         start, busy (start&!busy) op, side, price
// result    out        done (one-cycle strobe)   level_price, found
//
// A mark or a clear reads the leaf and mid words, writes them back, then returns
// to idle, where the next transfer is taken. A query walks top, mid and leaf with
// one find-first-set unit, and stops after the top level on an empty side.
// After reset busy stays high while the memories are cleared, one leaf word per
// cycle, with one mid word per cycle at the start of the pass.
// Results cannot be stalled: done is high for exactly one cycle per query.
`default_nettype none

module price_level_bitmap_index_top (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [plbi_pkg::OP_W-1:0]    op,
    input  wire                          side,
    input  wire  [plbi_pkg::PRICE_W-1:0] price,
    output logic                         done,
    output logic [plbi_pkg::PRICE_W-1:0] level_price,
    output logic                         found
);

    import plbi_pkg::*;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_UPD,
        ST_QTOP,
        ST_QMID,
        ST_QLEAF
    } state_t;

    state_t                 state_reg;
    logic [LEAF_MEM_AW-1:0] clr_cnt_reg;
    logic [OP_W-1:0]        op_reg;
    logic                   side_reg;
    logic [PRICE_W-1:0]     price_reg;
    word_t                  top_reg [2];
    bit_idx_t               bt_reg;
    bit_idx_t               bm_reg;
    logic                   done_reg;
    logic                   found_reg;
    logic [PRICE_W-1:0]     level_price_reg;

    // Bitmap memories, both sides in one array per level.
    word_t                  leaf_mem [LEAF_MEM_DEPTH];
    word_t                  mid_mem  [MID_MEM_DEPTH];
    word_t                  leaf_rd_reg;
    word_t                  mid_rd_reg;

    logic [LEAF_MEM_AW-1:0] leaf_raddr;
    logic [LEAF_MEM_AW-1:0] leaf_waddr;
    logic                   leaf_we;
    word_t                  leaf_wdata;
    logic [MID_MEM_AW-1:0]  mid_raddr;
    logic [MID_MEM_AW-1:0]  mid_waddr;
    logic                   mid_we;
    word_t                  mid_wdata;

    word_t                  leaf_mask;
    word_t                  mid_mask;
    word_t                  top_mask;
    word_t                  leaf_new;
    word_t                  mid_new;
    logic                   is_mark;

    word_t                  enc_word;
    bit_idx_t               enc_idx;

    // Price split into word indexes and bit positions per level.
    assign leaf_mask = word_t'(1) << price_reg[BIT_W-1:0];
    assign mid_mask  = word_t'(1) << price_reg[2*BIT_W-1:BIT_W];
    assign top_mask  = word_t'(1) << price_reg[PRICE_W-1:2*BIT_W];
    assign is_mark   = (op_reg == OP_MARK);

    // Read-modify-write values for mark and clear.
    assign leaf_new = is_mark ? (leaf_rd_reg | leaf_mask) : (leaf_rd_reg & ~leaf_mask);
    assign mid_new  = is_mark ? (mid_rd_reg | mid_mask) : (mid_rd_reg & ~mid_mask);

    // Shared find-first-set unit: the word comes from the level being walked.
    always_comb
    begin
        unique case (state_reg)
            ST_QTOP:  enc_word = top_reg[side_reg];
            ST_QMID:  enc_word = mid_rd_reg;
            default:  enc_word = leaf_rd_reg;
        endcase
        enc_idx = (side_reg == SIDE_SELL) ? low_bit(enc_word) : high_bit(enc_word);
    end

    // Memory addresses and write controls.
    always_comb
    begin
        leaf_raddr = {side_reg, price_reg[PRICE_W-1:BIT_W]};
        mid_raddr  = {side_reg, price_reg[PRICE_W-1:2*BIT_W]};
        if (state_reg == ST_QMID) begin
            leaf_raddr = {side_reg, bt_reg, enc_idx};
        end
        if (state_reg == ST_QTOP) begin
            mid_raddr = {side_reg, enc_idx};
        end

        leaf_waddr = {side_reg, price_reg[PRICE_W-1:BIT_W]};
        leaf_wdata = leaf_new;
        leaf_we    = (state_reg == ST_UPD);
        mid_waddr  = {side_reg, price_reg[PRICE_W-1:2*BIT_W]};
        mid_wdata  = mid_new;
        mid_we     = (state_reg == ST_UPD) && (is_mark || (leaf_new == '0));

        // The clearing pass after reset overrides the write controls.
        if (state_reg == ST_CLR) begin
            leaf_waddr = clr_cnt_reg;
            leaf_wdata = '0;
            leaf_we    = 1'b1;
            mid_waddr  = clr_cnt_reg[MID_MEM_AW-1:0];
            mid_wdata  = '0;
            mid_we     = (clr_cnt_reg[LEAF_MEM_AW-1:MID_MEM_AW] == '0);
        end
    end

    // Leaf memory with registered read.
    always_ff @(posedge clk)
    begin
        if (leaf_we) begin
            leaf_mem[leaf_waddr] <= leaf_wdata;
        end
        leaf_rd_reg <= leaf_mem[leaf_raddr];
    end

    // Mid memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mid_we) begin
            mid_mem[mid_waddr] <= mid_wdata;
        end
        mid_rd_reg <= mid_mem[mid_raddr];
    end

    // Command payload captured on each transfer.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start) begin
            op_reg    <= op;
            side_reg  <= side;
            price_reg <= price;
        end
    end

    // Sequencer, top words and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_CLR;
            clr_cnt_reg     <= '0;
            top_reg[0]      <= '0;
            top_reg[1]      <= '0;
            bt_reg          <= '0;
            bm_reg          <= '0;
            done_reg        <= 1'b0;
            found_reg       <= 1'b0;
            level_price_reg <= '0;
        end else begin
            // The result strobe follows the last level walked by a query.
            done_reg <= (state_reg == ST_QLEAF) ||
                        (state_reg == ST_QTOP && top_reg[side_reg] == '0);
            unique case (state_reg)
                ST_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start) begin
                        unique case (op)
                            OP_MARK:  state_reg <= ST_RD;
                            OP_CLEAR: state_reg <= ST_RD;
                            OP_QUERY: state_reg <= ST_QTOP;
                            default:  state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    // A parent bit drops only when the word below has emptied.
                    if (is_mark) begin
                        top_reg[side_reg] <= top_reg[side_reg] | top_mask;
                    end else if (leaf_new == '0 && mid_new == '0) begin
                        top_reg[side_reg] <= top_reg[side_reg] & ~top_mask;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_QTOP:
                begin
                    bt_reg <= enc_idx;
                    if (top_reg[side_reg] == '0) begin
                        found_reg       <= 1'b0;
                        level_price_reg <= '0;
                        state_reg       <= ST_IDLE;
                    end else begin
                        state_reg <= ST_QMID;
                    end
                end
                ST_QMID:
                begin
                    bm_reg    <= enc_idx;
                    state_reg <= ST_QLEAF;
                end
                ST_QLEAF:
                begin
                    found_reg       <= 1'b1;
                    level_price_reg <= {bt_reg, bm_reg, enc_idx};
                    state_reg       <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign level_price = level_price_reg;

endmodule

`default_nettype wire

/* verif/tb_price_level_bitmap_index_top.sv */
`timescale 1ns / 100ps

module tb_price_level_bitmap_index_top;

    localparam int PRICE_W      = plbi_pkg::PRICE_W;
    localparam int RANDOM_ITEMS = 1500;
    localparam int SWEEP_EVERY  = 250;

    // The one op code that the block decodes to nothing.
    localparam logic [plbi_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [plbi_pkg::OP_W-1:0] op;
        logic                      side;
        logic [PRICE_W-1:0]        price;
        int                        gap;
        bit                        hold;
    } book_cmd_t;

    typedef struct packed {
        logic [PRICE_W-1:0] level_price;
        logic               found;
    } quote_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [plbi_pkg::OP_W-1:0] op = plbi_pkg::OP_MARK;
    logic                      side = plbi_pkg::SIDE_BUY;
    logic [PRICE_W-1:0]        price = '0;
    logic                      busy;
    logic                      done;
    logic [PRICE_W-1:0]        level_price;
    logic                      found;

    // Commands waiting to be driven, and quotes waiting to come back.
    book_cmd_t cmd_pend_q [$];
    quote_t    quote_due_q [$];

    // Predicted occupancy bitmaps, indexed by side (0 buy, 1 sell).
    logic [63:0] leaf_words [2][4096];
    logic [63:0] mid_words [2][64];
    logic [63:0] top_words [2];

    // Prices marked by the generator and not yet cleared, as {side, price}.
    logic [PRICE_W:0]   live_px_q [$];
    logic [PRICE_W-1:0] hot_base = '0;
    int                 quiet_left = 0;

    int     gap_left = 0;
    logic   cmd_taken = 1'b0;
    int     mism_count = 0;
    quote_t want;
    book_cmd_t nxt;

    price_level_bitmap_index_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .side        (side),
        .price       (price),
        .done        (done),
        .level_price (level_price),
        .found       (found)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Position of the lowest set bit; a zero word gives 0.
    function automatic int lowest_one(input logic [63:0] w);
        int pos;
        pos = 0;
        for (int i = 63; i >= 0; i--)
        begin
            if (w[i])
                pos = i;
        end
        return pos;
    endfunction

    // Position of the highest set bit; a zero word gives 0.
    function automatic int highest_one(input logic [63:0] w);
        int pos;
        pos = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (w[i])
                pos = i;
        end
        return pos;
    endfunction

    // Applies one accepted command to the predicted bitmaps and, for a query,
    // records the quote that the block must return.
    task automatic apply_book_cmd(input logic [plbi_pkg::OP_W-1:0] c_op,
                                  input logic c_side, input logic [PRICE_W-1:0] c_px);
        int     s;
        int     t;
        int     m;
        int     l;
        bit     sell;
        quote_t q;
        sell = (c_side == plbi_pkg::SIDE_SELL);
        s = sell ? 1 : 0;
        case (c_op)
            plbi_pkg::OP_MARK:
            begin
                leaf_words[s][c_px[17:6]][c_px[5:0]] = 1'b1;
                mid_words[s][c_px[17:12]][c_px[11:6]] = 1'b1;
                top_words[s][c_px[17:12]] = 1'b1;
            end
            plbi_pkg::OP_CLEAR:
            begin
                // Parents are cleared only once the word below has emptied.
                leaf_words[s][c_px[17:6]][c_px[5:0]] = 1'b0;
                if (leaf_words[s][c_px[17:6]] == '0)
                begin
                    mid_words[s][c_px[17:12]][c_px[11:6]] = 1'b0;
                    if (mid_words[s][c_px[17:12]] == '0)
                        top_words[s][c_px[17:12]] = 1'b0;
                end
            end
            plbi_pkg::OP_QUERY:
            begin
                q.level_price = '0;
                q.found = 1'b0;
                if (top_words[s] != '0)
                begin
                    t = sell ? lowest_one(top_words[s]) : highest_one(top_words[s]);
                    m = sell ? lowest_one(mid_words[s][t]) : highest_one(mid_words[s][t]);
                    l = sell ? lowest_one(leaf_words[s][t * 64 + m])
                             : highest_one(leaf_words[s][t * 64 + m]);
                    q.level_price = PRICE_W'((t * 64 + m) * 64 + l);
                    q.found = 1'b1;
                end
                quote_due_q.push_back(q);
            end
            default:
            begin
            end
        endcase
    endtask

    // Idle time after a command: mostly none or short, now and then long, and
    // occasionally a stretch of back-to-back commands.
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Half the prices cluster around a moving base, so words fill and empty again.
    function automatic logic [PRICE_W-1:0] pick_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return hot_base + PRICE_W'($urandom_range(0, 191));
        if (r < 75)
            return PRICE_W'($urandom_range(0, 262143));
        if (r < 88)
            return PRICE_W'($urandom_range(0, 127));
        return PRICE_W'(262143 - $urandom_range(0, 127));
    endfunction

    task automatic queue_cmd(input logic [plbi_pkg::OP_W-1:0] c_op, input logic c_side,
                             input logic [PRICE_W-1:0] c_px, input bit c_hold);
        book_cmd_t c;
        c.op = c_op;
        c.side = c_side;
        c.price = c_px;
        c.gap = pick_gap();
        c.hold = c_hold;
        cmd_pend_q.push_back(c);
    endtask

    // Clears every live price in random order, so both sides end up empty,
    // then queries both sides once the earlier quotes have all arrived.
    task automatic sweep_book();
        int               k;
        logic [PRICE_W:0] e;
        while (live_px_q.size() != 0)
        begin
            k = $urandom_range(0, live_px_q.size() - 1);
            e = live_px_q[k];
            live_px_q.delete(k);
            queue_cmd(plbi_pkg::OP_CLEAR, e[PRICE_W], e[PRICE_W-1:0], 1'b0);
        end
        queue_cmd(plbi_pkg::OP_QUERY, plbi_pkg::SIDE_BUY, pick_price(), 1'b1);
        queue_cmd(plbi_pkg::OP_QUERY, plbi_pkg::SIDE_SELL, pick_price(), 1'b0);
        hot_base = PRICE_W'($urandom_range(0, 262143));
    endtask

    // Driver: a new command is presented once the previous transfer has
    // completed and any idle time has run out; a held one also waits for all quotes.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || cmd_taken)
            begin
                if (gap_left > 0)
                begin
                    start <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (cmd_pend_q.size() != 0 &&
                         !(cmd_pend_q[0].hold && quote_due_q.size() != 0))
                begin
                    nxt = cmd_pend_q.pop_front();
                    op <= nxt.op;
                    side <= nxt.side;
                    price <= nxt.price;
                    start <= 1'b1;
                    gap_left <= nxt.gap;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each quote against the oldest prediction, then feeds
    // the command accepted at this edge to the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_taken <= 1'b0;
            for (int s = 0; s < 2; s++)
            begin
                top_words[s] = '0;
                for (int i = 0; i < 64; i++)
                    mid_words[s][i] = '0;
                for (int i = 0; i < 4096; i++)
                    leaf_words[s][i] = '0;
            end
        end
        else
        begin
            cmd_taken <= start && !busy;
            if (done)
            begin
                if (quote_due_q.size() == 0)
                begin
                    $error("unexpected quote: level_price %0d, found %0d",
                           level_price, found);
                    mism_count++;
                end
                else
                begin
                    want = quote_due_q.pop_front();
                    if (level_price !== want.level_price)
                    begin
                        $error("level_price: expected %0d, actual %0d",
                               want.level_price, level_price);
                        mism_count++;
                    end
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, found);
                        mism_count++;
                    end
                end
            end
            if (start && !busy)
                apply_book_cmd(op, side, price);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int               r;
        int               spin;
        int               k;
        logic             sd;
        logic [PRICE_W-1:0] px;
        logic [PRICE_W:0] e;

        // Directed part: empty sides, price extremes, the unused op code,
        // clears of inactive prices and parent clearing across words.
        queue_cmd(plbi_pkg::OP_QUERY, plbi_pkg::SIDE_BUY, 18'h3FFFF, 1'b0);
        queue_cmd(plbi_pkg::OP_QUERY, plbi_pkg::SIDE_SELL, 18'h00000, 1'b0);
        queue_cmd(OP_UNUSED, plbi_pkg::SIDE_SELL, 18'h3FFFF, 1'b0);
        queue_cmd(plbi_pkg::OP_CLEAR, plbi_pkg::SIDE_BUY, 18'd5, 1'b0);
        queue_cmd(plbi_pkg::OP_MARK, plbi_pkg::SIDE_BUY, 18'h00000, 1'b0);
        queue_cmd(plbi_pkg::OP_MARK, plbi_pkg::SIDE_BUY, 18'h3FFFF, 1'b0);
        queue_cmd(plbi_pkg::OP_MARK, plbi_pkg::SIDE_SELL, 18'h00000, 1'b0);
        queue_cmd(plbi_pkg::OP_MARK, plbi_pkg::SIDE_SELL, 18'h3FFFF, 1'b0);
        queue_cmd(plbi_pkg::OP_QUERY, plbi_pkg::SIDE_BUY, 18'h00000, 1'b0);
        queue_cmd(plbi_pkg::OP_QUERY, plbi_pkg::SIDE_SELL, 18'h3FFFF, 1'b0);
        queue_cmd(plbi_pkg::OP_CLEAR, plbi_pkg::SIDE_SELL, 18'h00000, 1'b0);
        queue_cmd(plbi_pkg::OP_QUERY, plbi_pkg::SIDE_SELL, 18'h15555, 1'b0);
        queue_cmd(plbi_pkg::OP_CLEAR, plbi_pkg::SIDE_BUY, 18'h3FFFF, 1'b0);
        queue_cmd(plbi_pkg::OP_QUERY, plbi_pkg::SIDE_BUY, 18'h2AAAA, 1'b0);
        queue_cmd(plbi_pkg::OP_MARK, plbi_pkg::SIDE_SELL, 18'd64, 1'b0);
        queue_cmd(plbi_pkg::OP_MARK, plbi_pkg::SIDE_SELL, 18'd4096, 1'b0);
        queue_cmd(plbi_pkg::OP_QUERY, plbi_pkg::SIDE_SELL, 18'h00000, 1'b0);
        queue_cmd(plbi_pkg::OP_CLEAR, plbi_pkg::SIDE_SELL, 18'd100, 1'b0);
        queue_cmd(plbi_pkg::OP_CLEAR, plbi_pkg::SIDE_BUY, 18'd1, 1'b0);
        queue_cmd(plbi_pkg::OP_CLEAR, plbi_pkg::SIDE_BUY, 18'd0, 1'b0);
        queue_cmd(plbi_pkg::OP_QUERY, plbi_pkg::SIDE_BUY, 18'h3FFFF, 1'b0);
        queue_cmd(OP_UNUSED, plbi_pkg::SIDE_BUY, 18'h00000, 1'b0);
        queue_cmd(plbi_pkg::OP_CLEAR, plbi_pkg::SIDE_SELL, 18'd64, 1'b0);
        queue_cmd(plbi_pkg::OP_QUERY, plbi_pkg::SIDE_SELL, 18'h3FFFF, 1'b1);
        live_px_q.push_back({plbi_pkg::SIDE_SELL, 18'h3FFFF});
        live_px_q.push_back({plbi_pkg::SIDE_SELL, 18'd4096});
        hot_base = PRICE_W'($urandom_range(0, 262143));

        // Random part: mostly marks, clears of live prices and queries, with
        // some clears of arbitrary prices and unused op codes as noise.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n != 0 && n % SWEEP_EVERY == 0)
                sweep_book();
            r = $urandom_range(0, 99);
            sd = 1'($urandom_range(0, 1));
            if (r < 35 || (live_px_q.size() == 0 && r < 65))
            begin
                px = pick_price();
                live_px_q.push_back({sd, px});
                queue_cmd(plbi_pkg::OP_MARK, sd, px, 1'b0);
            end
            else if (r < 65)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    k = $urandom_range(0, live_px_q.size() - 1);
                    e = live_px_q[k];
                    live_px_q.delete(k);
                    queue_cmd(plbi_pkg::OP_CLEAR, e[PRICE_W], e[PRICE_W-1:0], 1'b0);
                end
                else
                begin
                    queue_cmd(plbi_pkg::OP_CLEAR, sd, pick_price(), 1'b0);
                end
            end
            else if (r < 95)
            begin
                queue_cmd(plbi_pkg::OP_QUERY, sd, PRICE_W'($urandom_range(0, 262143)), 1'b0);
            end
            else
            begin
                queue_cmd(OP_UNUSED, sd, PRICE_W'($urandom_range(0, 262143)), 1'b0);
            end
        end
        sweep_book();

        // Reset once; the block then clears its memories with busy held high.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_pend_q.size() != 0 || start)
            @(posedge clk);
        spin = 0;
        while (quote_due_q.size() != 0 && spin < 2000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (20) @(posedge clk);
        if (quote_due_q.size() != 0)
        begin
            $error("%0d quotes never arrived", quote_due_q.size());
            mism_count += quote_due_q.size();
        end

        if (mism_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
